[design/efd_pkg.sv]
// Shared widths, constants and the emitter descriptor type of the frame distributor.
`timescale 1ns / 1ps
`default_nettype none
package efd_pkg;

   localparam int EFD_MAX_FRAMES = 64;
   localparam int EFD_FRAC_BITS  = 8;

   localparam int START_W = 28;
   localparam int DUR_W   = 16;
   localparam int PHOT_W  = 32;
   localparam int POS_W   = 32;
   localparam int ID_W    = 32;
   localparam int INDEX_W = 20;
   localparam int TIME_W  = 30;
   localparam int OVL_W   = DUR_W + 1;
   localparam int PROD_W  = OVL_W + PHOT_W;
   localparam int REM_W   = PROD_W - PHOT_W;
   localparam int ROW_W   = 7;
   localparam int STEP_W  = $clog2(PHOT_W);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [START_W-1:0]      start;
      logic [DUR_W-1:0]        dur;
      logic [TIME_W-1:0]       stop;
      logic [PHOT_W-1:0]       photons;
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] z;
      logic [ID_W-1:0]         id;
      logic [START_W-1:0]      first;
      logic [ROW_W-1:0]        rows;
      logic                    clip;
   } efd_desc_type;

endpackage
`default_nettype wire

[design/emitter_frame_distributor.sv]
// Top level of the emitter frame distributor.
//
// Usage: one emitter beat on the req_ channel (start time, on-time, photons,
// position, id) yields one rsp_ beat per frame the emitter spans, at most
// MaxFrames of them, in frame order; rsp_last_row marks the final row and
// rsp_clipped is set on every row of an emitter whose span was cut short.
// An emitter whose span is empty yields no beat.
// Path: an accepted emitter passes the front-end register and the descriptor
// queue before the row engine takes it. The row engine works through each row
// in steps: the overlap, the multiply, the bit-serial divide by the on-time
// and the load of the output register, which offers the row on rsp_.
// The row engine finishes all rows of an emitter before it takes the next one.
// The front end and a two-entry descriptor queue keep taking emitters while
// the row engine works, so req_stall rises only once both are full.
// Reset clears all valid flags and the queue; no beat is pending afterward.
// When the receiver holds rsp_stall the output register keeps its row and the
// row engine waits with its next result until the register frees.
`timescale 1ns / 1ps
`default_nettype none
module emitter_frame_distributor
   import efd_pkg::*;
#(
   parameter int MaxFrames = EFD_MAX_FRAMES,
   parameter int FracBits  = EFD_FRAC_BITS
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [START_W-1:0]      req_start_time,
   input  wire logic [DUR_W-1:0]        req_on_duration,
   input  wire logic [PHOT_W-1:0]       req_photon_total,
   input  wire logic signed [POS_W-1:0] req_x_pos,
   input  wire logic signed [POS_W-1:0] req_y_pos,
   input  wire logic signed [POS_W-1:0] req_z_pos,
   input  wire logic [ID_W-1:0]         req_emitter_id,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [INDEX_W-1:0]           rsp_frame_index,
   output logic [PHOT_W-1:0]            rsp_frame_photons,
   output logic signed [POS_W-1:0]      rsp_out_x,
   output logic signed [POS_W-1:0]      rsp_out_y,
   output logic signed [POS_W-1:0]      rsp_out_z,
   output logic [ID_W-1:0]              rsp_out_id,
   output logic                         rsp_last_row,
   output logic                         rsp_clipped
);

   logic         front_valid, front_ready;
   efd_desc_type front_desc;
   logic         queue_valid, queue_ready;
   efd_desc_type queue_desc;

   efd_front #(
      .MaxFrames (MaxFrames),
      .FracBits  (FracBits)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_start_time   (req_start_time),
      .req_on_duration  (req_on_duration),
      .req_photon_total (req_photon_total),
      .req_x_pos        (req_x_pos),
      .req_y_pos        (req_y_pos),
      .req_z_pos        (req_z_pos),
      .req_emitter_id   (req_emitter_id),
      .desc_valid       (front_valid),
      .desc_ready       (front_ready),
      .desc             (front_desc)
   );

   efd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_desc   (front_desc),
      .out_valid (queue_valid),
      .out_ready (queue_ready),
      .out_desc  (queue_desc)
   );

   efd_back #(
      .FracBits (FracBits)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .desc_valid        (queue_valid),
      .desc_ready        (queue_ready),
      .desc              (queue_desc),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_frame_index   (rsp_frame_index),
      .rsp_frame_photons (rsp_frame_photons),
      .rsp_out_x         (rsp_out_x),
      .rsp_out_y         (rsp_out_y),
      .rsp_out_z         (rsp_out_z),
      .rsp_out_id        (rsp_out_id),
      .rsp_last_row      (rsp_last_row),
      .rsp_clipped       (rsp_clipped)
   );

endmodule
`default_nettype wire

[design/efd_front.sv]
// Front end: accepts emitter beats, finds the frame span and row count, drops empty spans.
`timescale 1ns / 1ps
`default_nettype none
module efd_front
   import efd_pkg::*;
#(
   parameter int MaxFrames = EFD_MAX_FRAMES,
   parameter int FracBits  = EFD_FRAC_BITS
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [START_W-1:0]      req_start_time,
   input  wire logic [DUR_W-1:0]        req_on_duration,
   input  wire logic [PHOT_W-1:0]       req_photon_total,
   input  wire logic signed [POS_W-1:0] req_x_pos,
   input  wire logic signed [POS_W-1:0] req_y_pos,
   input  wire logic signed [POS_W-1:0] req_z_pos,
   input  wire logic [ID_W-1:0]         req_emitter_id,
   output logic                         desc_valid,
   input  wire logic                    desc_ready,
   output efd_desc_type                 desc
);

   localparam logic [TIME_W-1:0] OneMinus1 = TIME_W'((1 << FracBits) - 1);
   localparam logic [TIME_W-1:0] MaxSpan   = TIME_W'(MaxFrames);

   logic         valid_ff, valid_in;
   efd_desc_type desc_ff, desc_in;
   logic         accept;
   logic [TIME_W-1:0] stop_w, past_w, first_w, span_w;

   assign req_stall  = valid_ff && !desc_ready;
   assign accept     = req_valid && !req_stall;
   assign desc_valid = valid_ff;
   assign desc       = desc_ff;

   always_comb begin
      stop_w  = TIME_W'(req_start_time) + TIME_W'(req_on_duration);
      past_w  = (stop_w + OneMinus1) >> FracBits;
      first_w = TIME_W'(req_start_time) >> FracBits;
      span_w  = past_w - first_w;

      desc_in         = desc_ff;
      desc_in.start   = req_start_time;
      desc_in.dur     = req_on_duration;
      desc_in.stop    = stop_w;
      desc_in.photons = req_photon_total;
      desc_in.x       = req_x_pos;
      desc_in.y       = req_y_pos;
      desc_in.z       = req_z_pos;
      desc_in.id      = req_emitter_id;
      desc_in.first   = first_w[START_W-1:0];
      if (span_w > MaxSpan) begin
         desc_in.rows = ROW_W'(MaxFrames);
         desc_in.clip = 1'b1;
      end else begin
         desc_in.rows = span_w[ROW_W-1:0];
         desc_in.clip = 1'b0;
      end

      if (accept) begin
         valid_in = (span_w != '0);
      end else if (desc_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         desc_ff <= desc_in;
      end
   end

endmodule
`default_nettype wire

[design/efd_queue.sv]
// Short descriptor queue between the front end and the row engine.
`timescale 1ns / 1ps
`default_nettype none
module efd_queue
   import efd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   output logic               in_ready,
   input  wire efd_desc_type  in_desc,
   output logic               out_valid,
   input  wire logic          out_ready,
   output efd_desc_type       out_desc
);

   efd_desc_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]      count_ff, count_in;
   logic                   push, pop;

   assign in_ready  = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_desc  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_desc;
      end
   end

endmodule
`default_nettype wire

[design/efd_back.sv]
// Row engine: walks the frames of one emitter, weights photons by a serial divide, emits rows.
`timescale 1ns / 1ps
`default_nettype none
module efd_back
   import efd_pkg::*;
#(
   parameter int FracBits = EFD_FRAC_BITS
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                desc_valid,
   output logic                     desc_ready,
   input  wire efd_desc_type        desc,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [INDEX_W-1:0]       rsp_frame_index,
   output logic [PHOT_W-1:0]        rsp_frame_photons,
   output logic signed [POS_W-1:0]  rsp_out_x,
   output logic signed [POS_W-1:0]  rsp_out_y,
   output logic signed [POS_W-1:0]  rsp_out_z,
   output logic [ID_W-1:0]          rsp_out_id,
   output logic                     rsp_last_row,
   output logic                     rsp_clipped
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_OVL  = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   localparam logic [TIME_W-1:0] One      = TIME_W'(1 << FracBits);
   localparam logic [STEP_W-1:0] StepLast = STEP_W'(PHOT_W - 1);

   logic [2:0]          state_ff, state_in;
   efd_desc_type        desc_ff, desc_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [OVL_W-1:0]    ovl_ff, ovl_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [PHOT_W-1:0]   quo_ff, quo_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0]  index_ff;
   logic [PHOT_W-1:0]   photons_ff;
   logic signed [POS_W-1:0] x_ff, y_ff, z_ff;
   logic [ID_W-1:0]     id_ff;
   logic                last_ff, clip_ff;

   logic [START_W-1:0]  frame;
   logic [TIME_W-1:0]   lo, hi, lo_cut, hi_cut;
   logic [PROD_W-1:0]   prod;
   logic [REM_W:0]      trial;
   logic                fits, last_row, load_out;

   assign desc_ready        = (state_ff == ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_index   = index_ff;
   assign rsp_frame_photons = photons_ff;
   assign rsp_out_x         = x_ff;
   assign rsp_out_y         = y_ff;
   assign rsp_out_z         = z_ff;
   assign rsp_out_id        = id_ff;
   assign rsp_last_row      = last_ff;
   assign rsp_clipped       = clip_ff;

   always_comb begin
      frame    = desc_ff.first + START_W'(row_ff);
      lo       = TIME_W'(frame) << FracBits;
      hi       = lo + One;
      lo_cut   = (TIME_W'(desc_ff.start) > lo) ? TIME_W'(desc_ff.start) : lo;
      hi_cut   = (desc_ff.stop < hi) ? desc_ff.stop : hi;
      prod     = PROD_W'(ovl_ff) * PROD_W'(desc_ff.photons);
      trial    = {rem_ff, quo_ff[PHOT_W-1]};
      fits     = (trial >= (REM_W + 1)'(desc_ff.dur));
      last_row = (row_ff + ROW_W'(1) == desc_ff.rows);
      load_out = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);

      state_in = state_ff;
      desc_in  = desc_ff;
      row_in   = row_ff;
      ovl_in   = ovl_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      step_in  = step_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (desc_valid) begin
               desc_in  = desc;
               row_in   = '0;
               state_in = ST_OVL;
            end
         end
         ST_OVL: begin
            ovl_in   = (hi_cut > lo_cut) ? OVL_W'(hi_cut - lo_cut) : '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            rem_in   = prod[PROD_W-1:PHOT_W];
            quo_in   = prod[PHOT_W-1:0];
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in  = fits ? REM_W'(trial - (REM_W + 1)'(desc_ff.dur)) : REM_W'(trial);
            quo_in  = {quo_ff[PHOT_W-2:0], fits};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == StepLast) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (load_out) begin
               if (last_row) begin
                  state_in = ST_IDLE;
               end else begin
                  row_in   = row_ff + ROW_W'(1);
                  state_in = ST_OVL;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      desc_ff <= desc_in;
      row_ff  <= row_in;
      ovl_ff  <= ovl_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
      if (load_out) begin
         index_ff   <= frame[INDEX_W-1:0];
         photons_ff <= (desc_ff.dur == '0) ? '0 : quo_ff;
         x_ff       <= desc_ff.x;
         y_ff       <= desc_ff.y;
         z_ff       <= desc_ff.z;
         id_ff      <= desc_ff.id;
         last_ff    <= last_row;
         clip_ff    <= desc_ff.clip;
      end
   end

endmodule
`default_nettype wire

[design/efd_checker.sv]
// Port-level checker of the frame distributor and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
module efd_checker
   import efd_pkg::*;
#(
   parameter int MaxFrames = EFD_MAX_FRAMES
) (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic [INDEX_W-1:0] rsp_frame_index,
   input wire logic [PHOT_W-1:0]  rsp_frame_photons,
   input wire logic [ID_W-1:0]    rsp_out_id,
   input wire logic               rsp_last_row,
   input wire logic               rsp_clipped
);

   logic               open_ff, open_in;
   logic [INDEX_W-1:0] index_ff;
   logic [ID_W-1:0]    id_ff;
   logic [ROW_W-1:0]   count_ff, count_in;
   logic               beat;

   assign beat = rsp_valid && !rsp_stall;

   always_comb begin
      open_in  = open_ff;
      count_in = count_ff;
      if (beat) begin
         open_in  = !rsp_last_row;
         count_in = rsp_last_row ? '0 : count_ff + ROW_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         open_ff  <= open_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (beat) begin
         index_ff <= rsp_frame_index;
         id_ff    <= rsp_out_id;
      end
   end

   a_reset_quiet : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat right after reset");

   a_hold_valid : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_frame_photons))
      else $error("stalled result beat dropped or changed");

   a_next_frame : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && open_ff |->
         rsp_frame_index == index_ff + INDEX_W'(1) && rsp_out_id == id_ff)
      else $error("row does not follow the previous frame of its emitter");

   a_clip_count : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_row && rsp_clipped |-> count_ff == ROW_W'(MaxFrames - 1))
      else $error("clipped emitter ended on the wrong row count");

endmodule

bind emitter_frame_distributor efd_checker #(
   .MaxFrames (MaxFrames)
) u_efd_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_frame_index   (rsp_frame_index),
   .rsp_frame_photons (rsp_frame_photons),
   .rsp_out_id        (rsp_out_id),
   .rsp_last_row      (rsp_last_row),
   .rsp_clipped       (rsp_clipped)
);
`default_nettype wire
